>>> sv/puct_child_select_top_macros.svh
// Assertion macros shared by the selection block.
`ifndef PUCT_CHILD_SELECT_TOP_MACROS_SVH
`define PUCT_CHILD_SELECT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PCS_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pcs_pkg.sv
`timescale 1ns / 1ps
package pcs_pkg;
    localparam int MAX_CHILDREN = 8;
    localparam int IDX_W        = $clog2(MAX_CHILDREN);
    localparam int CNT_W        = $clog2(MAX_CHILDREN + 1);
    localparam int VIS_W        = 16;
    localparam int VAL_W        = 32;
    localparam int PRI_W        = 16;
    localparam int BASE_W       = 20;
    localparam int INIT_W       = 24;
    localparam int OUT_IDX_W    = 6;
    localparam int REG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int SUM_W        = VIS_W + IDX_W;
    localparam int LARG_W       = ((SUM_W > BASE_W) ? SUM_W : BASE_W) + 1;
    localparam int LINT_W       = $clog2(LARG_W);
    localparam int FRAC_W       = 16;
    localparam int LOG_W        = LINT_W + FRAC_W;
    localparam int MANT_W       = 32;
    localparam int C_W          = ((LOG_W > INIT_W) ? LOG_W : INIT_W) + 1;
    localparam int NUM_W        = SUM_W + 32;
    localparam int SRC_W        = NUM_W + (NUM_W % 2);
    localparam int ROOT_W       = SRC_W / 2;
    localparam int SREM_W       = ROOT_W + 4;
    localparam int Q_W          = VAL_W + 1;
    localparam int TERM_W       = C_W + ROOT_W - 16;
    localparam int SCORE_W      = TERM_W + 2;
    localparam int STEP_W       = $clog2(NUM_W + 1);

    localparam logic [15:0] LN2_Q16 = 16'd45426;

    // Register indexes of the configuration port
    localparam logic [REG_IDX_W-1:0] REG_EXPLORE_BASE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_EXPLORE_INIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SELECT_MODE  = 2'd2;

    localparam logic [BASE_W-1:0] BASE_RESET = 20'd19652;
    localparam logic [INIT_W-1:0] INIT_RESET = 24'd81920;

    typedef struct packed {
        logic             legal;
        logic [PRI_W-1:0] prior;
        logic [VAL_W-1:0] value;
        logic [VIS_W-1:0] visits;
    } t_child;

    localparam int CHILD_W = $bits(t_child);
endpackage

>>> sv/pcs_in_if.sv
`timescale 1ns / 1ps
interface pcs_in_if;
    logic                      valid;
    logic                      ready;
    logic [pcs_pkg::VIS_W-1:0] visit_count;
    logic signed [pcs_pkg::VAL_W-1:0] total_value;
    logic [pcs_pkg::PRI_W-1:0] prior_prob;
    logic                      legal_move;
    logic                      last_child;

    modport source (output valid, visit_count, total_value, prior_prob, legal_move,
                    last_child, input ready);
    modport sink (input valid, visit_count, total_value, prior_prob, legal_move,
                  last_child, output ready);
endinterface

>>> sv/pcs_out_if.sv
`timescale 1ns / 1ps
interface pcs_out_if;
    logic                          valid;
    logic                          ready;
    logic [pcs_pkg::OUT_IDX_W-1:0] chosen_index;
    logic                          none_legal;

    modport source (output valid, chosen_index, none_legal, input ready);
    modport sink (input valid, chosen_index, none_legal, output ready);
endinterface

>>> sv/pcs_cfg_if.sv
`timescale 1ns / 1ps
interface pcs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pcs_pkg::REG_IDX_W-1:0]  reg_index;
    logic [pcs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink (input valid, reg_index, data, output ready);
endinterface

>>> sv/pcs_ram.sv
`timescale 1ns / 1ps
module pcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/puct_child_select_top.sv
`timescale 1ns / 1ps
`include "puct_child_select_top_macros.svh"
// PUCT child selection for one tree node.
// i_in carries one child per transaction (visits, total value, prior, legality);
// the transaction with last_child set closes the node. Up to MAX_CHILDREN children
// are kept in a child RAM; further children of the same node are dropped.
// o_out carries one transaction per node: the chosen child index and a flag
// that is set when mode 0 found no legal child. i_cfg writes explore_base,
// explore_init and select_mode by register index; it is always ready.
// Children are taken only while the block is in its load state. After the last
// child the block computes the exploration coefficient with one shared log2
// unit (two logs, each a normalize pass and then one squaring step per fraction
// bit, then one step that turns the difference into a natural log and adds
// explore_init), then visits each stored child in turn: RAM read (S_RD, S_INIT),
// a 51-step restoring divider (mean value divided alongside), a 26-step square
// root, then the product (S_MUL) and the compare (S_CMP). The result waits in
// an output register; the next node may load while it waits, and the block
// holds before writing a new result while the old one is still not taken.
// Reset (synchronous, active low) empties the load count, drops any pending
// result and restores the register defaults; the RAM contents are not cleared.
module puct_child_select_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcs_in_if.sink      i_in,
    pcs_out_if.source   o_out,
    pcs_cfg_if.sink     i_cfg
);
    import pcs_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_LOGN = 4'd1;
    localparam logic [3:0] S_LOGS = 4'd2;
    localparam logic [3:0] S_LN   = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_INIT = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_CMP  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    // Control and configuration
    logic [3:0]         r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_idx;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   r_sum_last;
    logic [BASE_W-1:0]  r_base;
    logic [INIT_W-1:0]  r_init;
    logic               r_mode;
    logic [STEP_W-1:0]  r_k;

    // Log unit
    logic [MANT_W-1:0]  r_lm;
    logic [LINT_W-1:0]  r_lp;
    logic [FRAC_W-1:0]  r_lfrac;
    logic               r_lsel;
    logic [LOG_W-1:0]   r_loga;
    logic [LOG_W-1:0]   r_logb;
    logic [C_W-1:0]     r_c;

    // Per-child datapath
    t_child             r_ch;
    logic [C_W-1:0]     r_cp;
    logic [NUM_W-1:0]   r_dquo;
    logic [VIS_W:0]     r_drem;
    logic [VIS_W:0]     r_dden;
    logic [VAL_W-1:0]   r_qquo;
    logic [VIS_W-1:0]   r_qrem;
    logic [SRC_W-1:0]   r_src;
    logic [SREM_W-1:0]  r_srem;
    logic [ROOT_W-1:0]  r_root;
    logic [TERM_W-1:0]  r_term;

    // Selection and output
    logic                      r_found;
    logic [IDX_W-1:0]          r_best_idx;
    logic [VIS_W-1:0]          r_best_vis;
    logic signed [SCORE_W-1:0] r_best_score;
    logic                      r_ovalid;
    logic [OUT_IDX_W-1:0]      r_oidx;
    logic                      r_onone;

    logic               w_acc;
    logic               w_store;
    logic               w_fin_go;
    logic [SUM_W-1:0]   n_sum;
    logic [BASE_W-1:0]  w_base;
    logic [LARG_W-1:0]  w_arga;
    logic [2*MANT_W-1:0] w_sq;
    logic [MANT_W:0]    w_sqt;
    logic [FRAC_W-1:0]  w_frac;
    logic [LOG_W-1:0]   w_lognew;
    logic [LOG_W+15:0]  w_lnprod;
    logic [VIS_W+1:0]   w_drsh;
    logic [VIS_W:0]     w_qrsh;
    logic [SREM_W+1:0]  w_srsh;
    logic [SREM_W+1:0]  w_trial;
    logic signed [Q_W-1:0]     w_q;
    logic signed [SCORE_W-1:0] w_score;
    logic               w_take;
    t_child             w_wchild;
    t_child             w_rchild;
    logic [CHILD_W-1:0] w_rdata;

    assign w_acc    = i_in.valid && i_in.ready;
    assign w_store  = r_cnt < CNT_W'(MAX_CHILDREN);
    assign w_fin_go = (r_state == S_FIN) && (!r_ovalid || o_out.ready);
    assign n_sum    = w_store ? r_sum + SUM_W'(i_in.visit_count) : r_sum;
    assign w_base   = (r_base == '0) ? BASE_W'(1) : r_base;
    assign w_arga   = LARG_W'(n_sum) + LARG_W'(w_base) + LARG_W'(1);

    assign w_wchild.legal  = i_in.legal_move;
    assign w_wchild.prior  = i_in.prior_prob;
    assign w_wchild.value  = i_in.total_value;
    assign w_wchild.visits = i_in.visit_count;
    assign w_rchild        = t_child'(w_rdata);

    // Child statistics RAM
    pcs_ram #(.WIDTH(CHILD_W), .DEPTH(MAX_CHILDREN)) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_store),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (w_wchild),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Squaring step of the log2 fraction
    always_comb begin
        w_sq     = r_lm * r_lm;
        w_sqt    = w_sq[2*MANT_W-1:MANT_W-1];
        w_frac   = r_lfrac;
        w_frac[r_k[$clog2(FRAC_W)-1:0]] = w_sqt[MANT_W];
        w_lognew = {r_lp, w_frac};
        w_lnprod = (r_loga - r_logb) * LN2_Q16;
    end

    // Divider, mean-value divider and square root steps, score and selection compare
    always_comb begin
        w_drsh  = {r_drem, r_dquo[NUM_W-1]};
        w_qrsh  = {r_qrem, r_qquo[VAL_W-1]};
        w_srsh  = {r_srem, r_src[SRC_W-1:SRC_W-2]};
        w_trial = (SREM_W + 2)'({r_root, 2'b01});
        if (r_ch.visits == '0) begin
            w_q = '0;
        end else if (r_ch.value[VAL_W-1]) begin
            w_q = -$signed({1'b0, r_qquo});
        end else begin
            w_q = $signed({1'b0, r_qquo});
        end
        w_score = $signed(SCORE_W'(w_q) | ({SCORE_W{w_q[Q_W-1]}} << Q_W))
                + $signed(SCORE_W'(r_term));
        if (!r_mode) begin
            w_take = r_ch.legal && (!r_found || w_score >= r_best_score);
        end else begin
            w_take = !r_found || r_ch.visits > r_best_vis
                   || (r_ch.visits == r_best_vis && w_score > r_best_score);
        end
    end

    assign i_in.ready  = (r_state == S_LOAD);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid        = r_ovalid;
    assign o_out.chosen_index = r_oidx;
    assign o_out.none_legal   = r_onone;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_init <= INIT_RESET;
            r_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_EXPLORE_BASE: r_base <= i_cfg.data[BASE_W-1:0];
                REG_EXPLORE_INIT: r_init <= i_cfg.data[INIT_W-1:0];
                REG_SELECT_MODE:  r_mode <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_n      <= '0;
        end else begin
            // load a new result, else drop the taken one
            if (w_fin_go) begin
                r_ovalid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (i_in.last_child) begin
                            r_n     <= w_store ? r_cnt + CNT_W'(1) : r_cnt;
                            r_cnt   <= '0;
                            r_sum   <= '0;
                            r_lm    <= {w_arga, (MANT_W - LARG_W)'(0)};
                            r_lp    <= LINT_W'(LARG_W - 1);
                            r_lsel  <= 1'b0;
                            r_state <= S_LOGN;
                        end else begin
                            r_cnt <= w_store ? r_cnt + CNT_W'(1) : r_cnt;
                            r_sum <= n_sum;
                        end
                    end
                end
                S_LOGN: begin
                    // shift the mantissa up until its top bit is set
                    if (r_lm[MANT_W-1]) begin
                        r_k     <= STEP_W'(FRAC_W - 1);
                        r_lfrac <= '0;
                        r_state <= S_LOGS;
                    end else begin
                        r_lm <= r_lm << 1;
                        r_lp <= r_lp - LINT_W'(1);
                    end
                end
                S_LOGS: begin
                    r_lfrac <= w_frac;
                    r_k     <= r_k - STEP_W'(1);
                    if (r_k == '0 && !r_lsel) begin
                        r_loga  <= w_lognew;
                        r_lsel  <= 1'b1;
                        r_lm    <= {w_base, (MANT_W - BASE_W)'(0)};
                        r_lp    <= LINT_W'(BASE_W - 1);
                        r_state <= S_LOGN;
                    end else begin
                        r_lm <= w_sqt[MANT_W] ? w_sqt[MANT_W:1] : w_sqt[MANT_W-1:0];
                        if (r_k == '0) begin
                            r_logb  <= w_lognew;
                            r_state <= S_LN;
                        end
                    end
                end
                S_LN: begin
                    r_c       <= C_W'(w_lnprod[LOG_W+15:16]) + C_W'(r_init);
                    r_idx     <= '0;
                    r_found   <= 1'b0;
                    r_best_idx <= '0;
                    r_state   <= S_RD;
                end
                S_RD: begin
                    // RAM address is r_idx; data arrives next cycle
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    r_ch    <= w_rchild;
                    r_cp    <= C_W'(((C_W + PRI_W)'(r_c) * (C_W + PRI_W)'(w_rchild.prior))
                                    >> 16);
                    r_dquo  <= {r_sum_last, 32'd0};
                    r_drem  <= '0;
                    r_dden  <= (VIS_W + 1)'(w_rchild.visits) + (VIS_W + 1)'(1);
                    r_qquo  <= w_rchild.value[VAL_W-1] ? VAL_W'(-w_rchild.value)
                                                       : w_rchild.value;
                    r_qrem  <= '0;
                    r_k     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per cycle; mean value uses the first steps
                    if (w_drsh >= {1'b0, r_dden}) begin
                        r_drem <= (VIS_W + 1)'(w_drsh - {1'b0, r_dden});
                        r_dquo <= {r_dquo[NUM_W-2:0], 1'b1};
                    end else begin
                        r_drem <= w_drsh[VIS_W:0];
                        r_dquo <= {r_dquo[NUM_W-2:0], 1'b0};
                    end
                    if (r_k < STEP_W'(VAL_W) && r_ch.visits != '0) begin
                        if (w_qrsh >= {1'b0, r_ch.visits}) begin
                            r_qrem <= VIS_W'(w_qrsh - {1'b0, r_ch.visits});
                            r_qquo <= {r_qquo[VAL_W-2:0], 1'b1};
                        end else begin
                            r_qrem <= w_qrsh[VIS_W-1:0];
                            r_qquo <= {r_qquo[VAL_W-2:0], 1'b0};
                        end
                    end
                    if (r_k == STEP_W'(NUM_W - 1)) begin
                        r_k     <= '0;
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_src   <= SRC_W'(w_drsh >= {1'b0, r_dden} ?
                                   {r_dquo[NUM_W-2:0], 1'b1} : {r_dquo[NUM_W-2:0], 1'b0});
                        r_state <= S_SQRT;
                    end else begin
                        r_k <= r_k + STEP_W'(1);
                    end
                end
                S_SQRT: begin
                    // one root bit per cycle from two radicand bits
                    if (w_srsh >= w_trial) begin
                        r_srem <= SREM_W'(w_srsh - w_trial);
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_srem <= SREM_W'(w_srsh);
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_src <= r_src << 2;
                    r_k   <= r_k + STEP_W'(1);
                    if (r_k == STEP_W'(ROOT_W - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_term  <= TERM_W'(((C_W + ROOT_W)'(r_cp) * (C_W + ROOT_W)'(r_root))
                                       >> 16);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_take) begin
                        r_found      <= 1'b1;
                        r_best_idx   <= r_idx[IDX_W-1:0];
                        r_best_vis   <= r_ch.visits;
                        r_best_score <= w_score;
                    end
                    r_idx <= r_idx + CNT_W'(1);
                    r_state <= (r_idx + CNT_W'(1) == r_n) ? S_FIN : S_RD;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (w_fin_go) begin
                        r_oidx   <= r_found ? OUT_IDX_W'(r_best_idx) : '0;
                        r_onone  <= !r_mode && !r_found;
                        r_state  <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // Visit total of the node being scored
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && w_acc && i_in.last_child) begin
            r_sum_last <= n_sum;
        end
    end

    `PCS_ASSERT_NXT(a_last_starts_log, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.last_child, r_state == S_LOGN, "last child did not start the log pass")
    `PCS_ASSERT_IMM(a_cnt_bound, i_clk, i_rst_n, r_state == S_LOAD, r_cnt <= CNT_W'(MAX_CHILDREN), "load count past capacity")
    `PCS_ASSERT_IMM(a_cmp_range, i_clk, i_rst_n, r_state == S_CMP, r_idx < r_n, "scored child beyond stored count")
    `PCS_ASSERT_IMM(a_out_from_fin, i_clk, i_rst_n, $rose(r_ovalid), $past(r_state) == S_FIN, "result raised outside finish")
endmodule

>>> bench/tb_puct_child_select_top.sv
`timescale 1ns / 1ps
module tb_puct_child_select_top;
    import pcs_pkg::*;

    typedef struct {
        logic [VIS_W-1:0] visits;
        logic [VAL_W-1:0] value;
        logic [PRI_W-1:0] prior;
        logic             legal;
        logic             last;
    } t_tb_child;

    typedef struct {
        logic [OUT_IDX_W-1:0] index;
        logic                 none;
    } t_choice;

    logic i_clk;
    logic i_rst_n;

    pcs_in_if  in_if();
    pcs_out_if out_if();
    pcs_cfg_if cfg_if();

    puct_child_select_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    t_tb_child pending_children[$];
    t_choice   expected_choices[$];
    int        error_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    // Local copy of the node store and registers
    logic [VIS_W-1:0]  node_visits[MAX_CHILDREN];
    int                node_value[MAX_CHILDREN];
    logic [PRI_W-1:0]  node_prior[MAX_CHILDREN];
    logic              node_legal[MAX_CHILDREN];
    int                node_count;
    logic [BASE_W-1:0] cur_base;
    logic [INIT_W-1:0] cur_init;
    logic              cur_mode;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Q16 log2 by repeated squaring of a Q1.31 mantissa
    function automatic logic [63:0] log2_fix(input logic [63:0] x);
        int unsigned p;
        logic [63:0] m;
        logic [63:0] r;
        p = 0;
        if (x == 0) x = 1;
        while (p < 40 && (x >> (p + 1)) != 0) p++;
        m = (p <= 31) ? (x << (31 - p)) : (x >> (p - 31));
        r = 64'(p) << 16;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                r[i] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] root_fix(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Load one child; on the closing child pick the winner
    task automatic load_and_select(input t_tb_child ch);
        logic [63:0] sum, base, lnq, coef, root, term;
        longint      q, score, best_score;
        logic [VIS_W-1:0] best_visits;
        bit          found;
        int          chosen;
        int          n;
        t_choice     res;
        if (node_count < MAX_CHILDREN) begin
            node_visits[node_count] = ch.visits;
            node_value[node_count]  = ch.value;
            node_prior[node_count]  = ch.prior;
            node_legal[node_count]  = ch.legal;
            node_count++;
        end
        if (!ch.last) return;
        n = node_count;
        node_count = 0;
        sum = 0;
        for (int i = 0; i < n; i++) sum += node_visits[i];
        base = (cur_base != 0) ? 64'(cur_base) : 64'd1;
        lnq = ((log2_fix(sum + base + 1) - log2_fix(base)) * 64'(LN2_Q16)) >> 16;
        coef = lnq + 64'(cur_init);
        found = 0;
        chosen = 0;
        best_score = 0;
        best_visits = 0;
        for (int i = 0; i < n; i++) begin
            q = (node_visits[i] != 0) ? longint'(node_value[i]) / longint'(node_visits[i]) : 0;
            root = root_fix((sum << 32) / (64'(node_visits[i]) + 1));
            term = (((coef * 64'(node_prior[i])) >> 16) * root) >> 16;
            score = q + longint'(term);
            if (cur_mode == 1'b0) begin
                if (node_legal[i] && (!found || score >= best_score)) begin
                    found = 1;
                    chosen = i;
                    best_score = score;
                end
            end else if (!found || node_visits[i] > best_visits
                         || (node_visits[i] == best_visits && score > best_score)) begin
                found = 1;
                chosen = i;
                best_visits = node_visits[i];
                best_score = score;
            end
        end
        res.index = OUT_IDX_W'(chosen);
        res.none  = (cur_mode == 1'b0) && !found;
        expected_choices.push_back(res);
    endtask

    // Drive child transactions from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_children.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                t_tb_child ch;
                ch = pending_children.pop_front();
                in_if.valid       <= 1'b1;
                in_if.visit_count <= ch.visits;
                in_if.total_value <= ch.value;
                in_if.prior_prob  <= ch.prior;
                in_if.legal_move  <= ch.legal;
                in_if.last_child  <= ch.last;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Track register writes, predict on accepted children, check results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.reg_index)
                    REG_EXPLORE_BASE: cur_base = cfg_if.data[BASE_W-1:0];
                    REG_EXPLORE_INIT: cur_init = cfg_if.data[INIT_W-1:0];
                    REG_SELECT_MODE:  cur_mode = cfg_if.data[0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                t_tb_child ch;
                ch.visits = in_if.visit_count;
                ch.value  = in_if.total_value;
                ch.prior  = in_if.prior_prob;
                ch.legal  = in_if.legal_move;
                ch.last   = in_if.last_child;
                load_and_select(ch);
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_choices.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index %0d",
                                              out_if.chosen_index));
                end else begin
                    t_choice want;
                    want = expected_choices.pop_front();
                    if (out_if.chosen_index !== want.index)
                        report_mismatch($sformatf("chosen_index %0d, want %0d",
                                                  out_if.chosen_index, want.index));
                    if (out_if.none_legal !== want.none)
                        report_mismatch($sformatf("none_legal %0b, want %0b",
                                                  out_if.none_legal, want.none));
                end
            end
        end
    end

    // Write one register, then drop valid and leave the channel idle
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.data      <= d;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_child(input logic [VIS_W-1:0] v, input logic [VAL_W-1:0] val,
                             input logic [PRI_W-1:0] p, input logic l, input logic last);
        t_tb_child ch;
        ch.visits = v;
        ch.value  = val;
        ch.prior  = p;
        ch.legal  = l;
        ch.last   = last;
        pending_children.push_back(ch);
    endtask

    // Random node; sizes mostly within the store, a few overflow it
    task automatic add_random_node(output int added);
        int n;
        logic [VIS_W-1:0] v;
        logic [VAL_W-1:0] val;
        logic [PRI_W-1:0] p;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = 16'hFFFF;
                2: v = VIS_W'($urandom_range(0, 3));
                default: v = VIS_W'($urandom);
            endcase
            val = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'h8000_0000
                                                                        : 32'h7FFF_FFFF)
                                              : $urandom;
            p = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                            : PRI_W'($urandom);
            add_child(v, val, p, $urandom_range(0, 3) != 0, i == n - 1);
        end
        added = n;
    endtask

    // Wait until the block has drained
    task automatic drain();
        while (pending_children.size() > 0 || in_if.valid || expected_choices.size() > 0)
            @(posedge i_clk);
        repeat (800) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [BASE_W-1:0] b, input logic [INIT_W-1:0] ci,
                             input logic m, input int idle, input int stall, input int items);
        int total, added;
        write_reg(REG_EXPLORE_BASE, CFG_DATA_W'(b));
        write_reg(REG_EXPLORE_INIT, ci);
        write_reg(REG_SELECT_MODE, CFG_DATA_W'(m));
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        total = 0;
        while (total < items) begin
            add_random_node(added);
            total += added;
        end
        drain();
    endtask

    initial begin
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        node_count     = 0;
        cur_base       = BASE_RESET;
        cur_init       = INIT_RESET;
        cur_mode       = 1'b0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.visit_count = '0;
        in_if.total_value = '0;
        in_if.prior_prob  = '0;
        in_if.legal_move  = 1'b0;
        in_if.last_child  = 1'b0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = '0;
        cfg_if.data      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed nodes under reset defaults
        add_child(16'h0, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
        add_child(16'hFFFF, 32'h8000_0000, 16'h0, 1'b1, 1'b0);
        add_child(16'h1, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
        // no legal child
        add_child(16'd5, 32'd100, 16'd200, 1'b0, 1'b0);
        add_child(16'd9, 32'd300, 16'd400, 1'b0, 1'b1);
        // exact tie: later child wins
        add_child(16'd3, 32'd65536, 16'd1000, 1'b1, 1'b0);
        add_child(16'd3, 32'd65536, 16'd1000, 1'b1, 1'b1);
        // too many children: the tail is dropped
        for (int i = 0; i < 11; i++)
            add_child(16'(i), 32'(i * 1000), (i >= 8) ? 16'hFFFF : 16'd10, 1'b1, i == 10);
        drain();

        // Mode 1 with a tie on visits, smallest base and init
        write_reg(REG_SELECT_MODE, CFG_DATA_W'(1));
        write_reg(REG_EXPLORE_BASE, CFG_DATA_W'(1));
        write_reg(REG_EXPLORE_INIT, '0);
        add_child(16'd7, 32'd10, 16'd5, 1'b0, 1'b0);
        add_child(16'd7, 32'd10, 16'd5, 1'b0, 1'b0);
        add_child(16'd7, 32'hFFFF_0000, 16'd5, 1'b1, 1'b1);
        add_child(16'd2, 32'd0, 16'd0, 1'b0, 1'b1);
        drain();

        run_phase(20'hFFFFF, 24'hFFFFFF, 1'b0, 0, 0, 100);
        run_phase(20'h0, 24'd81920, 1'b1, 50, 0, 100);
        run_phase(20'd19652, 24'h0, 1'b0, 0, 50, 100);
        run_phase(20'd1, 24'hFFFFFF, 1'b1, 19, 19, 100);
        run_phase(20'($urandom), 24'($urandom), 1'b0, 50, 0, 100);
        run_phase(20'($urandom), 24'($urandom), 1'b1, 0, 50, 100);
        run_phase(20'($urandom), 24'($urandom), 1'b0, 19, 19, 100);
        run_phase(20'd19652, 24'd81920, 1'b0, 0, 0, 100);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/pcs_pkg.sv
sv/pcs_in_if.sv
sv/pcs_out_if.sv
sv/pcs_cfg_if.sv
sv/pcs_ram.sv
sv/puct_child_select_top.sv
bench/tb_puct_child_select_top.sv
